// ----- hdl/slx_pkg.sv -----
// Shared types and constants for the script lexer byte stream block.
// No dependencies; every other file of the block imports this package.
package slx_pkg;

    localparam int MAX_TOKEN_LEN_DEF = 127;
    localparam int POSITION_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 4;

    localparam logic [2:0] K_STRING = 3'd0;
    localparam logic [2:0] K_PUNCT  = 3'd1;
    localparam logic [2:0] K_PAIR   = 3'd2;
    localparam logic [2:0] K_CMP    = 3'd3;
    localparam logic [2:0] K_DEC    = 3'd4;
    localparam logic [2:0] K_HEX    = 3'd5;
    localparam logic [2:0] K_IDENT  = 3'd6;
    localparam logic [2:0] K_ZERO   = 3'd7;

    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_ILLEGAL = 3'd1;
    localparam logic [2:0] E_QUOTE   = 3'd2;
    localparam logic [2:0] E_PAIR    = 3'd3;
    localparam logic [2:0] E_ZERO    = 3'd4;

    typedef struct packed {
        logic valid;
        logic pair;
    } t_q_head;

endpackage

// ----- hdl/slx_front.sv -----
// Lexer front end: accepts source bytes, tracks position and token state,
// and forms up to two result records per byte. Depends on slx_pkg.
module slx_front
    import slx_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1),
    localparam int P     = POSITION_BITS,
    localparam int REC_W = 17 + LEN_W + 2 * POSITION_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_space,
    output logic             o_ready,
    output logic             o_push,
    output logic             o_pair,
    output logic [REC_W-1:0] o_rec0,
    output logic [REC_W-1:0] o_rec1
);

    typedef enum logic [8:0] {
        M_IDLE    = 9'b000000001,
        M_COMMENT = 9'b000000010,
        M_STRING  = 9'b000000100,
        M_PAIR    = 9'b000001000,
        M_CMP     = 9'b000010000,
        M_ZERO    = 9'b000100000,
        M_HEX     = 9'b001000000,
        M_DEC     = 9'b010000000,
        M_IDENT   = 9'b100000000
    } t_mode;

    localparam logic [7:0] CH_LF = 8'h0A;

    t_mode            r_mode, n_mode;
    logic [7:0]       r_quote, n_quote;
    logic [7:0]       r_pfirst, n_pfirst;
    logic [LEN_W-1:0] r_plen, n_plen;
    logic [P-1:0]     r_pline, n_pline;
    logic [P-1:0]     r_pcol, n_pcol;
    logic [P-1:0]     r_line, n_line;
    logic [P-1:0]     r_col, n_col;
    logic             r_drop, n_drop;

    logic             accept;
    logic [LEN_W-1:0] g_len;
    logic [REC_W-1:0] v_a, v_b, v_c;
    logic             v_av, v_bv, v_cv;
    logic             v_again, v_err;
    logic [7:0]       c;

    function automatic logic is_space(input logic [7:0] ch);
        return ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'h30 && ch <= 8'h39;
    endfunction

    function automatic logic is_alpha(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A);
    endfunction

    function automatic logic is_hex(input logic [7:0] ch);
        return is_digit(ch) || (ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66);
    endfunction

    function automatic logic [REC_W-1:0] mk(
        input logic             has,
        input logic [2:0]       kind,
        input logic [7:0]       first,
        input logic [LEN_W-1:0] len,
        input logic [P-1:0]     line,
        input logic [P-1:0]     col,
        input logic [2:0]       err
    );
        logic tl;
        tl = has && (len >= LEN_W'(MAX_TOKEN_LEN));
        return {1'b0, err, col, line, tl, len, first, kind, has};
    endfunction

    assign o_ready = i_space;
    assign accept  = i_valid && i_space;
    assign c       = i_byte;
    assign g_len   = (r_plen < LEN_W'(MAX_TOKEN_LEN)) ? r_plen + LEN_W'(1) : r_plen;

    always_comb begin
        n_mode   = r_mode;
        n_quote  = r_quote;
        n_pfirst = r_pfirst;
        n_plen   = r_plen;
        n_pline  = r_pline;
        n_pcol   = r_pcol;
        n_line   = r_line;
        n_col    = r_col;
        n_drop   = r_drop;
        v_a      = '0;
        v_b      = '0;
        v_c      = '0;
        v_av     = 1'b0;
        v_bv     = 1'b0;
        v_cv     = 1'b0;
        v_again  = 1'b0;
        v_err    = 1'b0;

        if (!r_drop) begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    n_plen = g_len;
                    if (c == r_quote) begin
                        v_a    = mk(1'b1, K_STRING, r_pfirst, g_len, r_pline, r_pcol, E_NONE);
                        v_av   = 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_PAIR: begin
                    if (c == r_pfirst) begin
                        n_plen = g_len;
                        v_a    = mk(1'b1, K_PAIR, r_pfirst, g_len, r_pline, r_pcol, E_NONE);
                        v_av   = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        v_a   = mk(1'b0, 3'd0, r_pfirst, '0, r_pline, r_pcol, E_PAIR);
                        v_av  = 1'b1;
                        v_err = 1'b1;
                    end
                end
                M_CMP: begin
                    if (c == 8'h3D) begin
                        n_plen = g_len;
                        v_a    = mk(1'b1, K_CMP, r_pfirst, g_len, r_pline, r_pcol, E_NONE);
                        v_av   = 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        v_a     = mk(1'b1, K_CMP, r_pfirst, r_plen, r_pline, r_pcol, E_NONE);
                        v_av    = 1'b1;
                        v_again = 1'b1;
                    end
                end
                M_ZERO: begin
                    if (is_space(c) || c == 8'h2C || c == 8'h3B || c == 8'h29
                        || c == 8'h23) begin
                        v_a     = mk(1'b1, K_ZERO, r_pfirst, r_plen, r_pline, r_pcol, E_NONE);
                        v_av    = 1'b1;
                        v_again = 1'b1;
                    end else if (c == 8'h78 || c == 8'h58) begin
                        n_plen = g_len;
                        n_mode = M_HEX;
                    end else begin
                        v_a   = mk(1'b0, 3'd0, r_pfirst, '0, r_pline, r_pcol, E_ZERO);
                        v_av  = 1'b1;
                        v_err = 1'b1;
                    end
                end
                M_HEX: begin
                    if (is_hex(c)) begin
                        n_plen = g_len;
                    end else begin
                        v_a     = mk(1'b1, K_HEX, r_pfirst, r_plen, r_pline, r_pcol, E_NONE);
                        v_av    = 1'b1;
                        v_again = 1'b1;
                    end
                end
                M_DEC: begin
                    if (is_digit(c)) begin
                        n_plen = g_len;
                    end else begin
                        v_a     = mk(1'b1, K_DEC, r_pfirst, r_plen, r_pline, r_pcol, E_NONE);
                        v_av    = 1'b1;
                        v_again = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_alpha(c) || is_digit(c) || c == 8'h5F) begin
                        n_plen = g_len;
                    end else begin
                        v_a     = mk(1'b1, K_IDENT, r_pfirst, r_plen, r_pline, r_pcol, E_NONE);
                        v_av    = 1'b1;
                        v_again = 1'b1;
                    end
                end
                default: begin
                    v_again = 1'b1;
                end
            endcase

            if (v_again) begin
                n_mode = M_IDLE;
                priority if (c == 8'h22 || c == 8'h27) begin
                    n_mode   = M_STRING;
                    n_quote  = c;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (c == 8'h23) begin
                    n_mode = M_COMMENT;
                end else if (c == 8'h28 || c == 8'h29 || c == 8'h7B || c == 8'h7D
                             || c == 8'h3B || c == 8'h2C || c == 8'h21) begin
                    v_b  = mk(1'b1, K_PUNCT, c, LEN_W'(1), r_line, r_col, E_NONE);
                    v_bv = 1'b1;
                end else if (c == 8'h26 || c == 8'h7C) begin
                    n_mode   = M_PAIR;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (c == 8'h3D || c == 8'h3C || c == 8'h3E) begin
                    n_mode   = M_CMP;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (c == 8'h30) begin
                    n_mode   = M_ZERO;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (is_digit(c)) begin
                    n_mode   = M_DEC;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (is_alpha(c) || c == 8'h5F) begin
                    n_mode   = M_IDENT;
                    n_pfirst = c;
                    n_plen   = LEN_W'(1);
                    n_pline  = r_line;
                    n_pcol   = r_col;
                end else if (!is_space(c)) begin
                    v_b   = mk(1'b0, 3'd0, c, '0, r_line, r_col, E_ILLEGAL);
                    v_bv  = 1'b1;
                    v_err = 1'b1;
                end else begin
                    n_mode = M_IDLE;
                end
            end

            if (c == CH_LF) begin
                n_line = (r_line != {P{1'b1}}) ? r_line + P'(1) : r_line;
                n_col  = '0;
            end else begin
                n_col = (r_col != {P{1'b1}}) ? r_col + P'(1) : r_col;
            end

            if (v_err) begin
                n_drop = 1'b1;
                n_mode = M_IDLE;
            end else if (i_last) begin
                unique case (n_mode)
                    M_STRING: begin
                        v_c  = mk(1'b0, 3'd0, n_pfirst, '0, n_pline, n_pcol, E_QUOTE);
                        v_cv = 1'b1;
                    end
                    M_PAIR: begin
                        v_c  = mk(1'b0, 3'd0, n_pfirst, '0, n_pline, n_pcol, E_PAIR);
                        v_cv = 1'b1;
                    end
                    M_ZERO: begin
                        v_c  = mk(1'b0, 3'd0, n_pfirst, '0, n_pline, n_pcol, E_ZERO);
                        v_cv = 1'b1;
                    end
                    M_CMP: begin
                        v_c  = mk(1'b1, K_CMP, n_pfirst, n_plen, n_pline, n_pcol, E_NONE);
                        v_cv = 1'b1;
                    end
                    M_HEX: begin
                        v_c  = mk(1'b1, K_HEX, n_pfirst, n_plen, n_pline, n_pcol, E_NONE);
                        v_cv = 1'b1;
                    end
                    M_DEC: begin
                        v_c  = mk(1'b1, K_DEC, n_pfirst, n_plen, n_pline, n_pcol, E_NONE);
                        v_cv = 1'b1;
                    end
                    M_IDENT: begin
                        v_c  = mk(1'b1, K_IDENT, n_pfirst, n_plen, n_pline, n_pcol, E_NONE);
                        v_cv = 1'b1;
                    end
                    default: begin
                        v_cv = 1'b0;
                    end
                endcase
            end
        end

        if (i_last && !v_av && !v_bv && !v_cv) begin
            v_c  = '0;
            v_cv = 1'b1;
        end

        if (i_last) begin
            n_mode   = M_IDLE;
            n_quote  = '0;
            n_pfirst = '0;
            n_plen   = '0;
            n_pline  = '0;
            n_pcol   = '0;
            n_line   = '0;
            n_col    = '0;
            n_drop   = 1'b0;
        end
    end

    always_comb begin
        o_pair = (v_av && (v_bv || v_cv)) || (v_bv && v_cv);
        o_push = accept && (v_av || v_bv || v_cv);
        o_rec0 = v_av ? v_a : (v_bv ? v_b : v_c);
        o_rec1 = (v_av && v_bv) ? v_b : v_c;
        o_rec0[REC_W-1] = i_last && !o_pair;
        o_rec1[REC_W-1] = i_last && o_pair;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_line <= '0;
            r_col  <= '0;
            r_drop <= 1'b0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_drop <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_quote  <= n_quote;
            r_pfirst <= n_pfirst;
            r_plen   <= n_plen;
            r_pline  <= n_pline;
            r_pcol   <= n_pcol;
        end
    end

endmodule

// ----- hdl/slx_queue.sv -----
// Short record queue between the lexer front end and the output stage,
// with a registered head entry. Depends on slx_pkg.
module slx_queue
    import slx_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH,
    parameter int W     = 2,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [W-1:0]  i_data,
    input  logic          i_pop,
    output logic          o_ready,
    output t_q_head       o_head,
    output logic [W-2:0]  o_data
);

    logic [W-1:0]     r_mem [DEPTH];
    logic [W-1:0]     r_rdata;
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_count, n_count, v_after_pop;

    always_comb begin
        n_wr        = i_push ? ((r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1)) : r_wr;
        n_rd        = i_pop ? ((r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1)) : r_rd;
        v_after_pop = r_count - CNT_W'(i_pop);
        n_count     = v_after_pop + CNT_W'(i_push);
    end

    assign o_ready      = r_count < CNT_W'(DEPTH);
    assign o_head.valid = r_count != '0;
    assign o_head.pair  = r_rdata[W-1];
    assign o_data       = r_rdata[W-2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (i_push && v_after_pop == '0) begin
            r_rdata <= i_data;
        end else begin
            r_rdata <= r_mem[n_rd];
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue occupancy above depth");
    a_push_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CNT_W'(DEPTH)))
        else $error("push into a full queue");
`endif

endmodule

// ----- hdl/slx_back.sv -----
// Output stage: splits queued record pairs into single beats and holds
// each beat in an output register until taken. Depends on slx_pkg.
module slx_back
    import slx_pkg::*;
#(
    parameter int REC_W = 56,
    localparam int TD_W = ((REC_W - 5 + 7) / 8) * 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_q_head            i_head,
    input  logic [2*REC_W-1:0] i_data,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [TD_W-1:0]    o_tdata,
    output logic [3:0]         o_tuser,
    output logic               o_tlast
);

    logic             r_valid;
    logic             r_sel, n_sel;
    logic [REC_W-1:0] r_rec;
    logic             v_load;

    assign v_load = !r_valid || i_tready;
    assign o_pop  = v_load && i_head.valid && (r_sel || !i_head.pair);
    assign n_sel  = i_head.pair && !r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else if (v_load) begin
            r_valid <= i_head.valid;
            if (i_head.valid) begin
                r_sel <= n_sel;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (v_load && i_head.valid) begin
            r_rec <= r_sel ? i_data[2*REC_W-1:REC_W] : i_data[REC_W-1:0];
        end
    end

    assign o_tvalid = r_valid;
    assign o_tuser  = r_rec[3:0];
    assign o_tdata  = TD_W'(r_rec[REC_W-2:4]);
    assign o_tlast  = r_rec[REC_W-1];

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_head.valid)
        else $error("pop from an empty queue");
    a_sel_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel |-> (i_head.valid && i_head.pair))
        else $error("second half selected without a pair at the head");
`endif

endmodule

// ----- hdl/script_lexer_byte_stream.sv -----
// Top level of the script lexer byte stream block: front end, record queue
// and output stage. Depends on slx_pkg, slx_front, slx_queue and slx_back.
//
// Source text enters one byte per beat on the slave side, tlast marking the
// last byte of a text; records leave one per beat on the master side, tlast
// marking the last record of a text. The front end takes one byte every
// cycle while the four-entry record queue has room. A byte that yields two
// records (a token closed by the byte that also opens or ends the next one)
// leaves as two beats through the single output register. A record is
// registered at the queue head and then in the output register before it
// appears. After the first error the rest of the text is consumed without
// records until its last byte.
module script_lexer_byte_stream
    import slx_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF,
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1),
    localparam int REC_W = 17 + LEN_W + 2 * POSITION_BITS,
    localparam int TD_W  = ((REC_W - 5 + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [7:0]      s_axis_tdata,  // text_byte
    input  logic            s_axis_tlast,  // end_of_text
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // first_char, token_length, too_long, start_line, start_column, error_code
    output logic [TD_W-1:0] m_axis_tdata,
    output logic [3:0]      m_axis_tuser,  // has_token, token_kind
    output logic            m_axis_tlast   // final_result
);

    logic             push, pair, space, pop;
    logic [REC_W-1:0] rec0, rec1;
    t_q_head          head;
    logic [2*REC_W-1:0] head_data;

    slx_front #(
        .MAX_TOKEN_LEN(MAX_TOKEN_LEN),
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_space (space),
        .o_ready (s_axis_tready),
        .o_push  (push),
        .o_pair  (pair),
        .o_rec0  (rec0),
        .o_rec1  (rec1)
    );

    slx_queue #(
        .DEPTH(QUEUE_DEPTH),
        .W    (2 * REC_W + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({pair, rec1, rec0}),
        .i_pop   (pop),
        .o_ready (space),
        .o_head  (head),
        .o_data  (head_data)
    );

    slx_back #(
        .REC_W(REC_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_data   (head_data),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for script_lexer_byte_stream: streams random and directed source texts,
// predicts every token and fault record and compares them on the master side beat by beat.
// Depends only on slx_pkg and the script_lexer_byte_stream RTL.
`timescale 1ns / 1ps

module testbench
    import slx_pkg::*;
();

    localparam int REC_TD_W    = 56;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    localparam string IDENT_HEAD = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_";
    localparam string IDENT_TAIL = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz_0123456789";
    localparam string DIGITS     = "0123456789";
    localparam string HEX_DIGITS = "0123456789abcdefABCDEF";

    typedef enum logic [8:0] {
        LX_IDLE    = 9'b000000001,
        LX_COMMENT = 9'b000000010,
        LX_STRING  = 9'b000000100,
        LX_PAIR    = 9'b000001000,
        LX_CMP     = 9'b000010000,
        LX_ZERO    = 9'b000100000,
        LX_HEX     = 9'b001000000,
        LX_DEC     = 9'b010000000,
        LX_IDENT   = 9'b100000000
    } t_lex_mode;

    typedef enum int {
        PH_DIRECTED, PH_STEADY, PH_SPARSE_IN, PH_SLOW_OUT, PH_MIXED, PH_BACKPRESSURE, PH_SATURATE
    } t_traffic_phase;

    typedef struct packed {
        logic        has_token;
        logic [2:0]  kind;
        logic [7:0]  first;
        logic [6:0]  length;
        logic        too_long;
        logic [15:0] line;
        logic [15:0] column;
        logic [2:0]  fault;
        logic        last_of_text;
    } t_lex_record;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_text_beat;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata  = 8'h00;  // text_byte
    logic                s_axis_tlast  = 1'b0;   // end_of_text
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // first_char, token_length, too_long, start_line, start_column, error_code
    logic [REC_TD_W-1:0] m_axis_tdata;
    logic [3:0]          m_axis_tuser;           // has_token, token_kind
    logic                m_axis_tlast;           // final_result

    script_lexer_byte_stream i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    t_text_beat     pending_beats[$];
    logic [7:0]     text_buf[$];
    t_lex_record    expected_recs[$];
    t_lex_record    step_recs[$];
    t_text_beat     next_beat;
    t_traffic_phase phase     = PH_DIRECTED;
    int unsigned    gap_pct   = 0;
    int unsigned    stall_pct = 0;
    int             hold_left = 0;
    bit             hold_done = 1'b0;
    int             quiet_cycles = 0;
    int             texts_queued = 0;
    int             bytes_sent   = 0;
    int             recs_checked = 0;
    int             tokens_seen  = 0;
    int             fail_count   = 0;

    // Lexer shadow state.
    t_lex_mode   lx_mode  = LX_IDLE;
    logic [7:0]  quote_ch = 8'h00;
    logic [7:0]  tok_first = 8'h00;
    logic [6:0]  tok_len   = 7'd0;
    logic [15:0] tok_line  = 16'd0;
    logic [15:0] tok_col   = 16'd0;
    logic [15:0] cur_line  = 16'd0;
    logic [15:0] cur_col   = 16'd0;
    bit          dropping  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit is_blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit is_letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    task automatic clear_lexer();
        lx_mode   = LX_IDLE;
        quote_ch  = 8'h00;
        tok_first = 8'h00;
        tok_len   = 7'd0;
        tok_line  = 16'd0;
        tok_col   = 16'd0;
        cur_line  = 16'd0;
        cur_col   = 16'd0;
        dropping  = 1'b0;
    endtask

    task automatic add_token(input logic [2:0] kind, input logic [7:0] first,
                             input logic [6:0] len, input logic [15:0] ln,
                             input logic [15:0] col);
        t_lex_record r;
        r = '0;
        r.has_token = 1'b1;
        r.kind      = kind;
        r.first     = first;
        r.length    = len;
        r.too_long  = (len >= MAX_TOKEN_LEN_DEF);
        r.line      = ln;
        r.column    = col;
        step_recs.push_back(r);
    endtask

    task automatic add_fault(input logic [7:0] first, input logic [15:0] ln,
                             input logic [15:0] col, input logic [2:0] code);
        t_lex_record r;
        r = '0;
        r.first  = first;
        r.line   = ln;
        r.column = col;
        r.fault  = code;
        step_recs.push_back(r);
    endtask

    task automatic close_token(input logic [2:0] kind);
        add_token(kind, tok_first, tok_len, tok_line, tok_col);
    endtask

    task automatic fault_at_token(input logic [2:0] code);
        add_fault(tok_first, tok_line, tok_col, code);
    endtask

    task automatic open_token(input t_lex_mode mode, input logic [7:0] c);
        lx_mode   = mode;
        tok_first = c;
        tok_len   = 7'd1;
        tok_line  = cur_line;
        tok_col   = cur_col;
    endtask

    task automatic grow_token();
        if (tok_len < MAX_TOKEN_LEN_DEF) tok_len++;
    endtask

    task automatic lex_fresh(input logic [7:0] c, output bit hit);
        hit = 1'b0;
        lx_mode = LX_IDLE;
        if (c == 8'h22 || c == 8'h27) begin
            open_token(LX_STRING, c);
            quote_ch = c;
        end else if (c == "#") begin
            lx_mode = LX_COMMENT;
        end else if (c == "(" || c == ")" || c == "{" || c == "}" || c == ";" || c == ","
                     || c == "!") begin
            add_token(K_PUNCT, c, 7'd1, cur_line, cur_col);
        end else if (c == "&" || c == "|") begin
            open_token(LX_PAIR, c);
        end else if (c == "=" || c == "<" || c == ">") begin
            open_token(LX_CMP, c);
        end else if (c == "0") begin
            open_token(LX_ZERO, c);
        end else if (is_digit(c)) begin
            open_token(LX_DEC, c);
        end else if (is_letter(c) || c == "_") begin
            open_token(LX_IDENT, c);
        end else if (!is_blank(c)) begin
            add_fault(c, cur_line, cur_col, E_ILLEGAL);
            hit = 1'b1;
        end
    endtask

    task automatic predict_byte(input logic [7:0] c, input logic eot);
        bit hit;
        bit relex;
        hit   = 1'b0;
        relex = 1'b0;
        step_recs.delete();
        if (dropping) begin
            if (eot) add_fault(8'h00, 16'd0, 16'd0, E_NONE);
        end else begin
            case (lx_mode)
                LX_COMMENT: if (c == 8'h0A) lx_mode = LX_IDLE;
                LX_STRING: begin
                    grow_token();
                    if (c == quote_ch) begin
                        close_token(K_STRING);
                        lx_mode = LX_IDLE;
                    end
                end
                LX_PAIR: begin
                    if (c == tok_first) begin
                        grow_token();
                        close_token(K_PAIR);
                        lx_mode = LX_IDLE;
                    end else begin
                        fault_at_token(E_PAIR);
                        hit = 1'b1;
                    end
                end
                LX_CMP: begin
                    if (c == "=") begin
                        grow_token();
                        close_token(K_CMP);
                        lx_mode = LX_IDLE;
                    end else begin
                        close_token(K_CMP);
                        relex = 1'b1;
                    end
                end
                LX_ZERO: begin
                    if (is_blank(c) || c == "," || c == ";" || c == ")" || c == "#") begin
                        close_token(K_ZERO);
                        relex = 1'b1;
                    end else if (c == "x" || c == "X") begin
                        grow_token();
                        lx_mode = LX_HEX;
                    end else begin
                        fault_at_token(E_ZERO);
                        hit = 1'b1;
                    end
                end
                LX_HEX: begin
                    if (is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
                        grow_token();
                    else begin
                        close_token(K_HEX);
                        relex = 1'b1;
                    end
                end
                LX_DEC: begin
                    if (is_digit(c)) grow_token();
                    else begin
                        close_token(K_DEC);
                        relex = 1'b1;
                    end
                end
                LX_IDENT: begin
                    if (is_letter(c) || is_digit(c) || c == "_") grow_token();
                    else begin
                        close_token(K_IDENT);
                        relex = 1'b1;
                    end
                end
                default: relex = 1'b1;
            endcase

            if (relex) lex_fresh(c, hit);

            if (c == 8'h0A) begin
                if (cur_line != 16'hFFFF) cur_line++;
                cur_col = 16'd0;
            end else if (cur_col != 16'hFFFF) begin
                cur_col++;
            end

            if (hit) begin
                dropping = 1'b1;
                lx_mode  = LX_IDLE;
            end else if (eot) begin
                case (lx_mode)
                    LX_STRING: fault_at_token(E_QUOTE);
                    LX_PAIR:   fault_at_token(E_PAIR);
                    LX_ZERO:   fault_at_token(E_ZERO);
                    LX_CMP:    close_token(K_CMP);
                    LX_HEX:    close_token(K_HEX);
                    LX_DEC:    close_token(K_DEC);
                    LX_IDENT:  close_token(K_IDENT);
                    default: ;
                endcase
                if (step_recs.size() == 0) add_fault(8'h00, 16'd0, 16'd0, E_NONE);
            end
        end

        if (eot) begin
            step_recs[step_recs.size() - 1].last_of_text = 1'b1;
            clear_lexer();
        end
        foreach (step_recs[i]) expected_recs.push_back(step_recs[i]);
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got) begin
            if (fail_count < 200)
                $display("%0t ns mismatch in %s: expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_record();
        t_lex_record want;
        t_lex_record got;
        got.first        = m_axis_tdata[7:0];
        got.length       = m_axis_tdata[14:8];
        got.too_long     = m_axis_tdata[15];
        got.line         = m_axis_tdata[31:16];
        got.column       = m_axis_tdata[47:32];
        got.fault        = m_axis_tdata[50:48];
        got.has_token    = m_axis_tuser[0];
        got.kind         = m_axis_tuser[3:1];
        got.last_of_text = m_axis_tlast;
        recs_checked++;
        if (got.has_token) tokens_seen++;
        if (expected_recs.size() == 0) begin
            if (fail_count < 200)
                $display("%0t ns record beat with nothing expected: expected none, actual 0x%0h",
                         $time, got);
            fail_count++;
        end else begin
            want = expected_recs.pop_front();
            check_field("has_token", want.has_token, got.has_token);
            check_field("token_kind", want.kind, got.kind);
            check_field("first_char", want.first, got.first);
            check_field("token_length", want.length, got.length);
            check_field("too_long", want.too_long, got.too_long);
            check_field("start_line", want.line, got.line);
            check_field("start_column", want.column, got.column);
            check_field("error_code", want.fault, got.fault);
            check_field("final_result", want.last_of_text, got.last_of_text);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_beats.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    next_beat = pending_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_beat.data;
                    s_axis_tlast  <= next_beat.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) check_record();
            if (phase == PH_BACKPRESSURE && !hold_done) begin
                hold_left     <= HOLD_CYCLES;
                hold_done     <= 1'b1;
                m_axis_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left     <= hold_left - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t ns no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [7:0] pick_char(input string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_buf.push_back(b);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    endtask

    task automatic flush_text();
        t_text_beat bt;
        foreach (text_buf[i]) begin
            bt.data = text_buf[i];
            bt.last = (i == text_buf.size() - 1);
            pending_beats.push_back(bt);
        end
        text_buf.delete();
        texts_queued++;
    endtask

    task automatic gen_text();
        int         n_pieces;
        int         sel;
        int         n;
        logic [7:0] q;
        logic [7:0] b;
        bit         open_end;
        open_end = 1'b0;
        n_pieces = $urandom_range(8, 1);
        for (int p = 0; p < n_pieces && !open_end; p++) begin
            sel = $urandom_range(99);
            if (sel < 16) begin
                put_byte(pick_char(IDENT_HEAD));
                n = ($urandom_range(40) == 0) ? $urandom_range(140, 126) : $urandom_range(8);
                repeat (n) put_byte(pick_char(IDENT_TAIL));
            end else if (sel < 27) begin
                put_byte(pick_char("123456789"));
                repeat ($urandom_range(5)) put_byte(pick_char(DIGITS));
            end else if (sel < 35) begin
                put_byte("0");
                put_byte(pick_char("xX"));
                repeat ($urandom_range(6)) put_byte(pick_char(HEX_DIGITS));
            end else if (sel < 42) begin
                put_byte("0");
                case ($urandom_range(5))
                    0: put_byte(8'h09 + 8'($urandom_range(4)));
                    1: put_byte(" ");
                    2: put_byte(",");
                    3: put_byte(";");
                    4: put_byte(")");
                    default: begin
                        put_byte("#");
                        put_byte(8'h0A);
                    end
                endcase
            end else if (sel < 54) begin
                q = $urandom_range(1) ? 8'h22 : 8'h27;
                put_byte(q);
                n = ($urandom_range(30) == 0) ? $urandom_range(150, 126) : $urandom_range(8);
                repeat (n) begin
                    b = 8'($urandom_range(255));
                    if (b == q) b = 8'h0A;
                    put_byte(b);
                end
                put_byte(q);
            end else if (sel < 65) begin
                put_byte(pick_char("(){};,!"));
            end else if (sel < 72) begin
                q = pick_char("&|");
                put_byte(q);
                put_byte(q);
            end else if (sel < 81) begin
                put_byte(pick_char("=<>"));
                if ($urandom_range(1)) put_byte("=");
            end else if (sel < 88) begin
                put_byte("#");
                repeat ($urandom_range(6)) put_byte(8'($urandom_range(8'h7E, 8'h20)));
                put_byte(8'h0A);
            end else if (sel < 94) begin
                repeat ($urandom_range(3, 1))
                    put_byte($urandom_range(1) ? 8'h20 : 8'h09 + 8'($urandom_range(4)));
            end else begin
                case ($urandom_range(4))
                    0: put_byte(8'($urandom_range(255)));
                    1: begin
                        put_byte(pick_char("&|"));
                        put_byte(pick_char("a=1 "));
                    end
                    2: begin
                        put_byte("0");
                        put_byte(pick_char("gqz_9("));
                    end
                    3: begin
                        put_byte(pick_char("\"'"));
                        repeat ($urandom_range(4)) put_byte(pick_char(IDENT_TAIL));
                        open_end = 1'b1;
                    end
                    default: begin
                        put_byte(pick_char("0&|"));
                        open_end = 1'b1;
                    end
                endcase
            end
            if (!open_end) begin
                case ($urandom_range(9))
                    3: put_byte(" ");
                    4: put_byte(8'h0A);
                    5: put_byte(8'h09);
                    6: begin
                        put_byte(8'h0D);
                        put_byte(8'h0A);
                    end
                    7: put_byte(",");
                    8: put_byte(";");
                    9: put_str("  ");
                    default: ;
                endcase
            end
        end
        flush_text();
    endtask

    task automatic wait_drain();
        while (pending_beats.size() != 0 || s_axis_tvalid || expected_recs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic start_phase(input t_traffic_phase p, input int unsigned gap,
                               input int unsigned stall);
        wait_drain();
        phase     = p;
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    task automatic run_random(input t_traffic_phase p, input int unsigned gap,
                              input int unsigned stall, input int n_bytes);
        start_phase(p, gap, stall);
        while (pending_beats.size() < n_bytes) gen_text();
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        put_str("x1<=0x");
        flush_text();
        put_str("'a\n'&&9");
        flush_text();
        put_str("0 ");
        flush_text();
        put_str("|x");
        flush_text();
        put_str("!\"ab");
        flush_text();
        put_str("#");
        flush_text();
        put_byte(8'hFF);
        flush_text();
        put_str("0a;");
        flush_text();
        put_byte(8'h00);
        flush_text();

        run_random(PH_STEADY, 0, 0, 320);
        run_random(PH_SPARSE_IN, 77, 0, 320);
        run_random(PH_SLOW_OUT, 0, 77, 320);
        run_random(PH_MIXED, 26, 26, 320);
        run_random(PH_BACKPRESSURE, 0, 0, 130);

        start_phase(PH_SATURATE, 0, 0);
        put_str("ab=0x1F 12");
        flush_text();
        repeat (200) put_byte(pick_char(IDENT_TAIL) | 8'h40);
        flush_text();
        put_byte(8'h27);
        repeat (150) put_byte(pick_char(IDENT_TAIL));
        put_byte(8'h27);
        flush_text();

        wait_drain();
        repeat (10) @(posedge i_clk);
        $display("Lexed %0d texts, %0d bytes, over four idle mixes, a long output hold and %s",
                 texts_queued, bytes_sent, "length saturation.");
        $display("Checked %0d records: %0d tokens, %0d fault or empty end records.",
                 recs_checked, tokens_seen, recs_checked - tokens_seen);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
